// ===== hw/rtl/ckd_pkg.sv =====
package ckd_pkg;

   // sizes
   localparam int SINE_TABLE_BITS     = 10;
   localparam int MAX_SAMPLES_PER_BIT = 4096;
   localparam int SAMPLE_BITS         = 16;
   localparam int QUARTER_BITS        = SINE_TABLE_BITS - 2;
   localparam int QUARTER_SIZE        = 1 << QUARTER_BITS;
   localparam int PHASE_BITS          = 32;
   localparam int ACC_BITS            = 48;
   localparam int GAIN_BITS           = 16;
   localparam int GAIN_FRAC_BITS      = 12;
   localparam int SINE_BITS           = 16;
   localparam int CARRIER_BITS        = 20;
   localparam int PRODUCT_BITS        = SAMPLE_BITS + CARRIER_BITS;
   localparam int SPB_BITS            = 13;
   localparam int CNT_BITS            = $clog2(MAX_SAMPLES_PER_BIT);
   localparam int LIMIT_BITS          = CNT_BITS + 1;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QUEUE_PTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_BITS       = 3;
   localparam int CSR_DATA_BITS       = 48;
   localparam int RSP_TDATA_BITS      = 56;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FSK_MODE        = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PHASE_STEP_ONE  = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PHASE_STEP_TWO  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PHASE_OFFSET    = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CARRIER_GAIN    = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SAMPLES_PER_BIT = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_THRESHOLD       = 3'd6;

   // configuration registers
   typedef struct packed {
      logic                       fsk_mode;
      logic [PHASE_BITS-1:0]      phase_step_one;
      logic [PHASE_BITS-1:0]      phase_step_two;
      logic [PHASE_BITS-1:0]      phase_offset;
      logic [GAIN_BITS-1:0]       carrier_gain;
      logic [SPB_BITS-1:0]        samples_per_bit;
      logic [ACC_BITS-1:0]        threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      fsk_mode:        1'b0,
      phase_step_one:  32'd35791394,
      phase_step_two:  32'd53687091,
      phase_offset:    32'd0,
      carrier_gain:    16'd4096,
      samples_per_bit: 13'd240,
      threshold:       48'd0
   };

   // one queued word from front to back
   typedef struct packed {
      logic [SAMPLE_BITS-1:0]     sample;
      logic [SINE_TABLE_BITS-1:0] idx_one;
      logic [SINE_TABLE_BITS-1:0] idx_two;
      logic                       restart;
      logic                       last;
   } item_type;

   typedef logic signed [SINE_BITS-1:0] quarter_rom_type [QUARTER_SIZE];

   // quarter-wave sine in Q1.15 from a Taylor series in Q30
   function automatic logic signed [SINE_BITS-1:0] quarter_sine(input int unsigned k);
      logic [63:0]        r;
      logic [63:0]        r2;
      logic [63:0]        term;
      logic signed [63:0] s;
      r    = (64'(k) * HALF_PI_Q30) / QUARTER_SIZE;
      r2   = (r * r) >> 30;
      term = r;
      s    = $signed(r);
      term = ((term * r2) >> 30) / 64'd6;
      s    = s - $signed(term);
      term = ((term * r2) >> 30) / 64'd20;
      s    = s + $signed(term);
      term = ((term * r2) >> 30) / 64'd42;
      s    = s - $signed(term);
      term = ((term * r2) >> 30) / 64'd72;
      s    = s + $signed(term);
      term = ((term * r2) >> 30) / 64'd110;
      s    = s - $signed(term);
      if (s < 0) begin
         s = 0;
      end
      s = (s + 64'sd16384) >>> 15;
      if (s > 64'sd32767) begin
         s = 64'sd32767;
      end
      return s[SINE_BITS-1:0];
   endfunction

   function automatic quarter_rom_type build_quarter();
      quarter_rom_type rom;
      for (int i = 0; i < QUARTER_SIZE; i++) begin
         rom[i] = quarter_sine(i);
      end
      return rom;
   endfunction

   localparam quarter_rom_type QUARTER_ROM = build_quarter();
   localparam logic signed [SINE_BITS-1:0] SINE_PEAK = quarter_sine(QUARTER_SIZE);

endpackage

// ===== hw/rtl/ckd_front.sv =====
module ckd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  ckd_pkg::cfg_type                    cfg,
   input  logic                                in_valid,
   input  logic [ckd_pkg::SAMPLE_BITS-1:0]     in_sample,
   input  logic                                in_restart,
   output logic                                in_ready,
   input  logic                                queue_full,
   output logic                                push,
   output ckd_pkg::item_type                   push_item
);

   logic [ckd_pkg::PHASE_BITS-1:0] phase_one_ff, phase_one_in;
   logic [ckd_pkg::PHASE_BITS-1:0] phase_two_ff, phase_two_in;
   logic [ckd_pkg::CNT_BITS-1:0]   count_ff, count_in;
   logic [ckd_pkg::PHASE_BITS-1:0] phase_one_base, phase_two_base;
   logic [ckd_pkg::PHASE_BITS-1:0] addr_one, addr_two;
   logic [ckd_pkg::CNT_BITS-1:0]   count_base;
   logic [ckd_pkg::LIMIT_BITS-1:0] count_next;
   logic [ckd_pkg::LIMIT_BITS-1:0] limit;
   logic                           last;

   assign in_ready = !queue_full;
   assign push     = in_valid && !queue_full;

   // period length, clamped to one .. max
   always_comb begin
      if (cfg.samples_per_bit == '0) begin
         limit = ckd_pkg::LIMIT_BITS'(1);
      end else if (cfg.samples_per_bit > ckd_pkg::LIMIT_BITS'(ckd_pkg::MAX_SAMPLES_PER_BIT)) begin
         limit = ckd_pkg::LIMIT_BITS'(ckd_pkg::MAX_SAMPLES_PER_BIT);
      end else begin
         limit = ckd_pkg::LIMIT_BITS'(cfg.samples_per_bit);
      end
   end

   // carrier phases, table addresses and bit counter
   always_comb begin
      phase_one_base = in_restart ? '0 : phase_one_ff;
      phase_two_base = in_restart ? '0 : phase_two_ff;
      count_base     = in_restart ? '0 : count_ff;
      addr_one       = phase_one_base + cfg.phase_offset;
      addr_two       = phase_two_base + cfg.phase_offset;
      count_next     = {1'b0, count_base} + ckd_pkg::LIMIT_BITS'(1);
      last           = count_next >= limit;

      push_item.sample  = in_sample;
      push_item.idx_one = addr_one[ckd_pkg::PHASE_BITS-1 -: ckd_pkg::SINE_TABLE_BITS];
      push_item.idx_two = addr_two[ckd_pkg::PHASE_BITS-1 -: ckd_pkg::SINE_TABLE_BITS];
      push_item.restart = in_restart;
      push_item.last    = last;

      phase_one_in = phase_one_ff;
      phase_two_in = phase_two_ff;
      count_in     = count_ff;
      if (push) begin
         phase_one_in = phase_one_base + cfg.phase_step_one;
         phase_two_in = phase_two_base + cfg.phase_step_two;
         count_in     = last ? '0 : count_next[ckd_pkg::CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_one_ff <= '0;
         phase_two_ff <= '0;
         count_ff     <= '0;
      end else begin
         phase_one_ff <= phase_one_in;
         phase_two_ff <= phase_two_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ===== hw/rtl/ckd_fifo.sv =====
module ckd_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  ckd_pkg::item_type                    push_item,
   input  logic                                 pop,
   output logic                                 full,
   output logic                                 rd_valid,
   output ckd_pkg::item_type                    rd_item,
   output logic [ckd_pkg::QUEUE_PTR_BITS:0]     count
);

   ckd_pkg::item_type                  entries_ff [ckd_pkg::QUEUE_DEPTH];
   ckd_pkg::item_type                  entries_in [ckd_pkg::QUEUE_DEPTH];
   logic [ckd_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ckd_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ckd_pkg::QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign full     = count_ff == (ckd_pkg::QUEUE_PTR_BITS+1)'(ckd_pkg::QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_item  = entries_ff[rd_ptr_ff];
   assign count    = count_ff;

   // pointers and fill level
   always_comb begin
      entries_in = entries_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         entries_in[wr_ptr_ff] = push_item;
         wr_ptr_in             = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/ckd_back.sv =====
module ckd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  ckd_pkg::cfg_type                    cfg,
   input  logic                                q_valid,
   input  ckd_pkg::item_type                   q_item,
   output logic                                pop,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                out_bit,
   output logic [ckd_pkg::ACC_BITS-1:0]        out_value,
   output logic                                out_last
);

   localparam int GP_BITS   = ckd_pkg::GAIN_BITS + ckd_pkg::SINE_BITS + 1;
   localparam int WIDE_BITS = ckd_pkg::ACC_BITS + 2;

   // table lookup with quadrant folding
   function automatic logic signed [ckd_pkg::SINE_BITS-1:0] sine_at(
      input logic [ckd_pkg::SINE_TABLE_BITS-1:0] idx);
      logic [ckd_pkg::QUARTER_BITS-1:0]       p;
      logic [ckd_pkg::QUARTER_BITS:0]         k;
      logic signed [ckd_pkg::SINE_BITS-1:0]   mag;
      p = idx[ckd_pkg::QUARTER_BITS-1:0];
      if (idx[ckd_pkg::QUARTER_BITS]) begin
         k = (ckd_pkg::QUARTER_BITS+1)'(ckd_pkg::QUARTER_SIZE) - {1'b0, p};
      end else begin
         k = {1'b0, p};
      end
      if (k[ckd_pkg::QUARTER_BITS]) begin
         mag = ckd_pkg::SINE_PEAK;
      end else begin
         mag = ckd_pkg::QUARTER_ROM[k[ckd_pkg::QUARTER_BITS-1:0]];
      end
      return idx[ckd_pkg::SINE_TABLE_BITS-1] ? -mag : mag;
   endfunction

   // gain times sine over 4096, truncated toward zero
   function automatic logic signed [ckd_pkg::CARRIER_BITS-1:0] scale(
      input logic [ckd_pkg::GAIN_BITS-1:0] gain,
      input logic signed [ckd_pkg::SINE_BITS-1:0] sine);
      logic signed [GP_BITS-1:0] gp;
      logic signed [GP_BITS-1:0] adj;
      gp  = $signed({1'b0, gain}) * sine;
      adj = gp + $signed({{(GP_BITS-ckd_pkg::GAIN_FRAC_BITS){1'b0}},
                          {ckd_pkg::GAIN_FRAC_BITS{gp[GP_BITS-1]}}});
      return adj[ckd_pkg::GAIN_FRAC_BITS +: ckd_pkg::CARRIER_BITS];
   endfunction

   // clamp to the 48-bit range
   function automatic logic [ckd_pkg::ACC_BITS-1:0] sat(input logic [WIDE_BITS-1:0] v);
      logic [ckd_pkg::ACC_BITS-1:0] r;
      if (v[WIDE_BITS-1:ckd_pkg::ACC_BITS-1] == '0 || v[WIDE_BITS-1:ckd_pkg::ACC_BITS-1] == '1) begin
         r = v[ckd_pkg::ACC_BITS-1:0];
      end else if (v[WIDE_BITS-1]) begin
         r = {1'b1, {(ckd_pkg::ACC_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(ckd_pkg::ACC_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic [WIDE_BITS-1:0] widen(input logic [ckd_pkg::ACC_BITS-1:0] v);
      return {{(WIDE_BITS-ckd_pkg::ACC_BITS){v[ckd_pkg::ACC_BITS-1]}}, v};
   endfunction

   logic advance;

   // stage a: sine lookup
   logic                                   a_valid_ff, a_valid_in;
   logic signed [ckd_pkg::SAMPLE_BITS-1:0] a_sample_ff, a_sample_in;
   logic signed [ckd_pkg::SINE_BITS-1:0]   a_sine_one_ff, a_sine_one_in;
   logic signed [ckd_pkg::SINE_BITS-1:0]   a_sine_two_ff, a_sine_two_in;
   logic                                   a_restart_ff, a_restart_in;
   logic                                   a_last_ff, a_last_in;
   // stage b: carrier amplitude
   logic                                   b_valid_ff, b_valid_in;
   logic signed [ckd_pkg::SAMPLE_BITS-1:0] b_sample_ff, b_sample_in;
   logic signed [ckd_pkg::CARRIER_BITS-1:0] b_car_one_ff, b_car_one_in;
   logic signed [ckd_pkg::CARRIER_BITS-1:0] b_car_two_ff, b_car_two_in;
   logic                                   b_restart_ff, b_restart_in;
   logic                                   b_last_ff, b_last_in;
   // stage c: mixing products
   logic                                   c_valid_ff, c_valid_in;
   logic signed [ckd_pkg::PRODUCT_BITS-1:0] c_prod_one_ff, c_prod_one_in;
   logic signed [ckd_pkg::PRODUCT_BITS-1:0] c_prod_two_ff, c_prod_two_in;
   logic                                   c_restart_ff, c_restart_in;
   logic                                   c_last_ff, c_last_in;
   // stage d: integrate and dump
   logic                                   d_valid_ff, d_valid_in;
   logic [ckd_pkg::ACC_BITS-1:0]           d_sum_one_ff, d_sum_one_in;
   logic [ckd_pkg::ACC_BITS-1:0]           d_sum_two_ff, d_sum_two_in;
   logic                                   d_last_ff, d_last_in;
   logic [ckd_pkg::ACC_BITS-1:0]           sum_one_ff, sum_one_in;
   logic [ckd_pkg::ACC_BITS-1:0]           sum_two_ff, sum_two_in;
   logic [ckd_pkg::ACC_BITS-1:0]           base_one, base_two;
   // stage e: decision value
   logic                                   e_valid_ff, e_valid_in;
   logic [ckd_pkg::ACC_BITS-1:0]           e_value_ff, e_value_in;
   logic                                   e_last_ff, e_last_in;
   // output word
   logic                                   o_valid_ff, o_valid_in;
   logic                                   o_bit_ff, o_bit_in;
   logic [ckd_pkg::ACC_BITS-1:0]           o_value_ff, o_value_in;
   logic                                   o_last_ff, o_last_in;

   // whole pipeline moves unless the output word is held
   assign advance   = !o_valid_ff || out_ready;
   assign pop       = q_valid && advance;
   assign out_valid = o_valid_ff;
   assign out_bit   = o_bit_ff;
   assign out_value = o_value_ff;
   assign out_last  = o_last_ff;

   always_comb begin
      a_valid_in    = q_valid;
      a_sample_in   = q_item.sample;
      a_sine_one_in = sine_at(q_item.idx_one);
      a_sine_two_in = sine_at(q_item.idx_two);
      a_restart_in  = q_item.restart;
      a_last_in     = q_item.last;

      b_valid_in    = a_valid_ff;
      b_sample_in   = a_sample_ff;
      b_car_one_in  = scale(cfg.carrier_gain, a_sine_one_ff);
      b_car_two_in  = scale(cfg.carrier_gain, a_sine_two_ff);
      b_restart_in  = a_restart_ff;
      b_last_in     = a_last_ff;

      c_valid_in    = b_valid_ff;
      c_prod_one_in = b_sample_ff * b_car_one_ff;
      c_prod_two_in = b_sample_ff * b_car_two_ff;
      c_restart_in  = b_restart_ff;
      c_last_in     = b_last_ff;

      // restart clears the sums before this sample is added
      base_one     = c_restart_ff ? '0 : sum_one_ff;
      base_two     = c_restart_ff ? '0 : sum_two_ff;
      d_valid_in   = c_valid_ff;
      d_sum_one_in = sat(widen(base_one) + WIDE_BITS'(c_prod_one_ff));
      d_sum_two_in = sat(widen(base_two) + WIDE_BITS'(c_prod_two_ff));
      d_last_in    = c_last_ff;
      sum_one_in   = sum_one_ff;
      sum_two_in   = sum_two_ff;
      if (c_valid_ff) begin
         sum_one_in = c_last_ff ? '0 : d_sum_one_in;
         sum_two_in = c_last_ff ? '0 : d_sum_two_in;
      end

      e_valid_in = d_valid_ff;
      e_value_in = cfg.fsk_mode ? sat(widen(d_sum_two_ff) - widen(d_sum_one_ff)) : d_sum_one_ff;
      e_last_in  = d_last_ff;

      o_valid_in = e_valid_ff;
      o_bit_in   = $signed(e_value_ff) >= $signed(cfg.threshold);
      o_value_in = e_value_ff;
      o_last_in  = e_last_ff;
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (advance) begin
         a_sample_ff   <= a_sample_in;
         a_sine_one_ff <= a_sine_one_in;
         a_sine_two_ff <= a_sine_two_in;
         a_restart_ff  <= a_restart_in;
         a_last_ff     <= a_last_in;
         b_sample_ff   <= b_sample_in;
         b_car_one_ff  <= b_car_one_in;
         b_car_two_ff  <= b_car_two_in;
         b_restart_ff  <= b_restart_in;
         b_last_ff     <= b_last_in;
         c_prod_one_ff <= c_prod_one_in;
         c_prod_two_ff <= c_prod_two_in;
         c_restart_ff  <= c_restart_in;
         c_last_ff     <= c_last_in;
         d_sum_one_ff  <= d_sum_one_in;
         d_sum_two_ff  <= d_sum_two_in;
         d_last_ff     <= d_last_in;
         e_value_ff    <= e_value_in;
         e_last_ff     <= e_last_in;
         o_bit_ff      <= o_bit_in;
         o_value_ff    <= o_value_in;
         o_last_ff     <= o_last_in;
      end
   end

   // valid bits and running sums
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         sum_one_ff <= '0;
         sum_two_ff <= '0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
         o_valid_ff <= o_valid_in;
         sum_one_ff <= sum_one_in;
         sum_two_ff <= sum_two_in;
      end
   end

endmodule

// ===== hw/rtl/coherent_keying_demodulator.sv =====
// channel   direction  handshake                 payload
// req       in         req_tvalid / req_tready   tdata: sample; tuser: restart
// rsp       out        rsp_tvalid / rsp_tready   tdata: bit_res, decision_value; tlast: bit_end
// csr       in         csr_we                    csr_addr, csr_wdata
//
// one word per cycle while rsp_tready holds; a word passes through the queue, then six back
// stages (sine lookup, gain multiply, mixing multiply, accumulate, decision value, output register)
// phase and bit counter loop in the front and the sum loop in the accumulate stage set the rate
// synchronous reset clears phases, counters, sums, queue and all valid bits; ready next cycle
// a held rsp word freezes the back pipeline; the four-word queue then fills and drops req_tready
module coherent_keying_demodulator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ckd_pkg::SAMPLE_BITS-1:0]        req_tdata,   // sample
   input  logic                                   req_tuser,   // restart
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ckd_pkg::RSP_TDATA_BITS-1:0]     rsp_tdata,   // bit_res, decision_value, zero pad
   output logic                                   rsp_tlast,   // bit_end
   input  logic                                   csr_we,
   input  logic [ckd_pkg::CSR_ADDR_BITS-1:0]      csr_addr,
   input  logic [ckd_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   ckd_pkg::cfg_type                    cfg_ff, cfg_in;
   ckd_pkg::item_type                   push_item, rd_item;
   logic                                push, pop, q_full, q_valid;
   logic [ckd_pkg::QUEUE_PTR_BITS:0]    q_count;
   logic                                out_bit;
   logic [ckd_pkg::ACC_BITS-1:0]        out_value;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            ckd_pkg::CSR_FSK_MODE:        cfg_in.fsk_mode        = csr_wdata[0];
            ckd_pkg::CSR_PHASE_STEP_ONE:  cfg_in.phase_step_one  = csr_wdata[ckd_pkg::PHASE_BITS-1:0];
            ckd_pkg::CSR_PHASE_STEP_TWO:  cfg_in.phase_step_two  = csr_wdata[ckd_pkg::PHASE_BITS-1:0];
            ckd_pkg::CSR_PHASE_OFFSET:    cfg_in.phase_offset    = csr_wdata[ckd_pkg::PHASE_BITS-1:0];
            ckd_pkg::CSR_CARRIER_GAIN:    cfg_in.carrier_gain    = csr_wdata[ckd_pkg::GAIN_BITS-1:0];
            ckd_pkg::CSR_SAMPLES_PER_BIT: cfg_in.samples_per_bit = csr_wdata[ckd_pkg::SPB_BITS-1:0];
            ckd_pkg::CSR_THRESHOLD:       cfg_in.threshold       = csr_wdata[ckd_pkg::ACC_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ckd_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: phases, addresses, bit counter
   ckd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_sample  (req_tdata),
      .in_restart (req_tuser),
      .in_ready   (req_tready),
      .queue_full (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   // queue between front and back
   ckd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (q_full),
      .rd_valid  (q_valid),
      .rd_item   (rd_item),
      .count     (q_count)
   );

   // back: mixing, integrate and dump, decision
   ckd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (rd_item),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_bit   (out_bit),
      .out_value (out_value),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {{(ckd_pkg::RSP_TDATA_BITS-ckd_pkg::ACC_BITS-1){1'b0}}, out_value, out_bit};

   // no result word straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= (ckd_pkg::QUEUE_PTR_BITS+1)'(ckd_pkg::QUEUE_DEPTH))
      else $error("queue fill level beyond depth");

   // fill level follows push and pop
   a_queue_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> q_count == $past(q_count) + 1'b1)
      else $error("queue fill level missed a push");

   a_queue_pop: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> q_count == $past(q_count) - 1'b1)
      else $error("queue fill level missed a pop");

endmodule
